// ===== hw/rtl/tss_pkg.sv =====
// Shared types and constants of the timelapse sample scheduler.
package tss_pkg;

    // Item field widths
    localparam int CMD_W   = 3;
    localparam int TIME_W  = 48;
    localparam int SEQ_W   = 48;
    localparam int DAY_W   = 27;
    localparam int STAMP_W = 49;
    localparam int DUE_W   = 49;
    localparam int CNT_W   = 32;

    // Configuration register widths
    localparam int IVL_W    = 17;
    localparam int RATE_W   = 7;
    localparam int FPF_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Register limits and reset values
    localparam logic [IVL_W-1:0]  MIN_INTERVAL_SEC = 17'd1;
    localparam logic [RATE_W-1:0] MIN_FPS          = 7'd1;
    localparam logic [RATE_W-1:0] MAX_FPS          = 7'd60;
    localparam logic [FPF_W-1:0]  MIN_FILE_FRAMES  = 16'd2;
    localparam logic [IVL_W-1:0]  IVL_RESET        = 17'd60;
    localparam logic [RATE_W-1:0] RATE_RESET       = 7'd30;
    localparam logic [FPF_W-1:0]  FPF_RESET        = 16'd0;

    // Multiplier operands
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 20;
    localparam logic [MUL_B_W-1:0] US_PER_SEC = 20'd1000000;
    localparam logic [MUL_B_W-1:0] TICKS_90K  = 20'd90000;

    // Divider sequencing
    localparam int DIV_STEPS = STAMP_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = RATE_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_FORCE  = 3'd1,
        CMD_TAKE   = 3'd2,
        CMD_RING   = 3'd3,
        CMD_FILE   = 3'd4,
        CMD_SAMPLE = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL    = 2'd0,
        CFG_RATE        = 2'd1,
        CFG_FILE_FRAMES = 2'd2
    } t_cfg_idx;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic tick_adv;
        logic tick_fix;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_sample;
        logic div_last;
    } t_dp_status;

endpackage

// ===== hw/rtl/tss_in_if.sv =====
// Input channel: one event per transfer.
interface tss_in_if;
    import tss_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [TIME_W-1:0]  now_time;
    logic [SEQ_W-1:0]   frame_seq;
    logic [DAY_W-1:0]   day_code;

    modport source (output valid, cmd, now_time, frame_seq, day_code, input ready);
    modport sink   (input valid, cmd, now_time, frame_seq, day_code, output ready);
endinterface

// ===== hw/rtl/tss_out_if.sv =====
// Output channel: one result per transfer.
interface tss_out_if;
    import tss_pkg::*;

    logic               valid;
    logic               ready;
    logic               sample_pending;
    logic               granted;
    logic               rotate_needed;
    logic [STAMP_W-1:0] stamp_90k;
    logic               stamp_valid;

    modport source (output valid, sample_pending, granted, rotate_needed, stamp_90k,
                    stamp_valid, input ready);
    modport sink   (input valid, sample_pending, granted, rotate_needed, stamp_90k,
                    stamp_valid, output ready);
endinterface

// ===== hw/rtl/tss_datapath.sv =====
// Datapath: config registers, scheduler state, shared multiplier and serial divider.
module tss_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tss_pkg::t_dp_cmd               i_cmd,
    output tss_pkg::t_dp_status            o_status,
    input  logic [tss_pkg::CMD_W-1:0]      i_item_cmd,
    input  logic [tss_pkg::TIME_W-1:0]     i_now_time,
    input  logic [tss_pkg::SEQ_W-1:0]      i_frame_seq,
    input  logic [tss_pkg::DAY_W-1:0]      i_day_code,
    input  logic                           i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_sample_pending,
    output logic                           o_granted,
    output logic                           o_rotate_needed,
    output logic [tss_pkg::STAMP_W-1:0]    o_stamp_90k,
    output logic                           o_stamp_valid
);
    import tss_pkg::*;

    // Configuration
    logic [IVL_W-1:0]  r_interval;
    logic [RATE_W-1:0] r_rate;
    logic [FPF_W-1:0]  r_fpf;

    // Scheduler state
    logic              r_flag;
    logic [DUE_W-1:0]  r_next_due;
    logic [SEQ_W-1:0]  r_taken_seq;
    logic [DAY_W-1:0]  r_open_day;
    logic [CNT_W-1:0]  r_frames_written;
    logic [CNT_W-1:0]  r_frame_index;

    // Latched item and working registers
    t_cmd              r_cmd;
    logic [TIME_W-1:0] r_now;
    logic [SEQ_W-1:0]  r_seq;
    logic [DAY_W-1:0]  r_day;
    logic              r_rotate;
    logic              r_granted;
    logic              r_adv;
    logic [STAMP_W-1:0] r_prod;
    logic [REM_W-1:0]  r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Output register payload
    logic               r_o_pending;
    logic               r_o_granted;
    logic               r_o_rotate;
    logic [STAMP_W-1:0] r_o_stamp;
    logic               r_o_svalid;

    logic [IVL_W-1:0]   cfg_ivl;
    logic [RATE_W-1:0]  cfg_rate;
    logic [FPF_W-1:0]   cfg_fpf;
    logic               rotate_now;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] mul_p;
    logic [DUE_W-1:0]   now_ext;
    logic [DUE_W-1:0]   now_plus;
    logic [DUE_W-1:0]   due_plus;
    logic [REM_W-1:0]   rem_sh;
    logic               rem_ge;

    // Clamp configuration writes
    always_comb begin
        cfg_ivl  = i_cfg_data[IVL_W-1:0];
        cfg_rate = i_cfg_data[RATE_W-1:0];
        cfg_fpf  = i_cfg_data[FPF_W-1:0];
        if (cfg_ivl < MIN_INTERVAL_SEC) begin
            cfg_ivl = MIN_INTERVAL_SEC;
        end
        if (cfg_rate < MIN_FPS) begin
            cfg_rate = MIN_FPS;
        end else if (cfg_rate > MAX_FPS) begin
            cfg_rate = MAX_FPS;
        end
        if ((cfg_fpf != '0) && (cfg_fpf < MIN_FILE_FRAMES)) begin
            cfg_fpf = MIN_FILE_FRAMES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= IVL_RESET;
            r_rate     <= RATE_RESET;
            r_fpf      <= FPF_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INTERVAL:    r_interval <= cfg_ivl;
                CFG_RATE:        r_rate     <= cfg_rate;
                CFG_FILE_FRAMES: r_fpf      <= cfg_fpf;
                default: ;
            endcase
        end
    end

    // Rotation check on state before the step
    always_comb begin
        if (r_open_day == '0) begin
            rotate_now = 1'b1;
        end else if (r_fpf != '0) begin
            rotate_now = r_frames_written >= {{(CNT_W-FPF_W){1'b0}}, r_fpf};
        end else begin
            rotate_now = i_day_code != r_open_day;
        end
    end

    // Shared multiplier: interval to microseconds, or frame index to 90 kHz ticks
    assign mul_a = (r_cmd == CMD_SAMPLE) ? r_frame_index
                                         : {{(MUL_A_W-IVL_W){1'b0}}, r_interval};
    assign mul_b = (r_cmd == CMD_SAMPLE) ? TICKS_90K : US_PER_SEC;
    assign mul_p = mul_a * mul_b;

    // Tick schedule sums
    assign now_ext  = {{(DUE_W-TIME_W){1'b0}}, r_now};
    assign now_plus = now_ext + r_prod;
    assign due_plus = r_next_due + r_prod;

    // Restoring divider step: one quotient bit per cycle
    assign rem_sh = {r_rem[REM_W-2:0], r_prod[STAMP_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_rate};

    // Item latch and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd     <= t_cmd'(i_item_cmd);
            r_now     <= i_now_time;
            r_seq     <= i_frame_seq;
            r_day     <= i_day_code;
            r_rotate  <= rotate_now;
            r_granted <= 1'b0;
            r_adv     <= 1'b0;
        end
        if (i_cmd.exec) begin
            r_prod    <= mul_p[STAMP_W-1:0];
            r_rem     <= '0;
            r_div_cnt <= '0;
            if ((r_cmd == CMD_TAKE) && r_flag && (r_seq > r_taken_seq)) begin
                r_granted <= 1'b1;
            end
        end
        if (i_cmd.tick_adv) begin
            r_adv <= (r_next_due != '0) && !(now_ext < r_next_due);
        end
        if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? (rem_sh - {1'b0, r_rate}) : rem_sh;
            r_prod    <= {r_prod[STAMP_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // Scheduler state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag           <= 1'b0;
            r_next_due       <= '0;
            r_taken_seq      <= '0;
            r_open_day       <= '0;
            r_frames_written <= '0;
            r_frame_index    <= '0;
        end else begin
            if (i_cmd.exec) begin
                case (r_cmd)
                    CMD_FORCE: r_flag <= 1'b1;
                    CMD_TAKE: begin
                        if (r_flag && (r_seq > r_taken_seq)) begin
                            r_taken_seq <= r_seq;
                            r_flag      <= 1'b0;
                        end
                    end
                    CMD_RING: r_taken_seq <= '0;
                    CMD_FILE: begin
                        r_open_day       <= r_day;
                        r_frames_written <= '0;
                        r_frame_index    <= '0;
                    end
                    CMD_SAMPLE: begin
                        r_frame_index    <= r_frame_index + 1'b1;
                        r_frames_written <= r_frames_written + 1'b1;
                    end
                    default: ;
                endcase
            end
            // First tick arms at once; a due tick arms and advances one interval
            if (i_cmd.tick_adv) begin
                if (r_next_due == '0) begin
                    r_flag     <= 1'b1;
                    r_next_due <= now_plus;
                end else if (!(now_ext < r_next_due)) begin
                    r_flag     <= 1'b1;
                    r_next_due <= due_plus;
                end
            end
            // Whole intervals were missed: restart from the present time
            if (i_cmd.tick_fix && r_adv && (r_next_due <= now_ext)) begin
                r_next_due <= now_plus;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_pending <= r_flag;
            r_o_granted <= r_granted;
            r_o_rotate  <= r_rotate;
            r_o_stamp   <= (r_cmd == CMD_SAMPLE) ? r_prod : '0;
            r_o_svalid  <= r_cmd == CMD_SAMPLE;
        end
    end

    assign o_status.is_tick   = r_cmd == CMD_TICK;
    assign o_status.is_sample = r_cmd == CMD_SAMPLE;
    assign o_status.div_last  = r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1);

    assign o_sample_pending = r_o_pending;
    assign o_granted        = r_o_granted;
    assign o_rotate_needed  = r_o_rotate;
    assign o_stamp_90k      = r_o_stamp;
    assign o_stamp_valid    = r_o_svalid;

endmodule

// ===== hw/rtl/tss_ctrl.sv =====
// Controller: sequences each event through the datapath and owns the handshakes.
module tss_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tss_pkg::t_dp_cmd     o_cmd,
    input  tss_pkg::t_dp_status  i_status
);
    import tss_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_TICK = 6'b000100,
        S_FIX  = 6'b001000,
        S_DIV  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load_out = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_tick) begin
                    n_state = S_TICK;
                end else if (i_status.is_sample) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_TICK: begin
                o_cmd.tick_adv = 1'b1;
                n_state        = S_FIX;
            end
            S_FIX: begin
                o_cmd.tick_fix = 1'b1;
                n_state        = S_EMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on load, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/timelapse_sample_scheduler.sv =====
// Top level of the timelapse sample scheduler.
//
// Takes one event per input transfer (tick, force, take, ring reset, file opened,
// sample) and returns one result per event. An event occupies the block from its
// input transfer until its result is loaded into the output register. Force, take,
// ring reset, file opened and unknown codes pass through one execute step; tick
// does one multiply, one advance and one catch-up check; sample runs the 49-step
// restoring divider that forms frame_index * 90000 / playback_rate one quotient
// bit per cycle. The output register holds a finished result until it is taken,
// so the next event is accepted while a result waits; a result stalled downstream
// holds the following event in its last cycle. Configuration writes are clamped
// to their legal ranges and take effect on the next event.
module timelapse_sample_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tss_in_if.sink                         i_in,
    tss_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tss_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tss_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer
    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // State, arithmetic and output register
    tss_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_item_cmd       (i_in.cmd),
        .i_now_time       (i_in.now_time),
        .i_frame_seq      (i_in.frame_seq),
        .i_day_code       (i_in.day_code),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_sample_pending (o_out.sample_pending),
        .o_granted        (o_out.granted),
        .o_rotate_needed  (o_out.rotate_needed),
        .o_stamp_90k      (o_out.stamp_90k),
        .o_stamp_valid    (o_out.stamp_valid)
    );

`ifndef SYNTHESIS
    // One event at a time: no input transfer right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an event is in progress");

    // A grant clears the request flag
    a_grant_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.granted) |-> !o_out.sample_pending)
        else $error("granted result still shows a pending request");

    // A stamp comes only from a sample event, never with a grant
    a_stamp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stamp_valid) |-> !o_out.granted)
        else $error("stamp and grant in the same result");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the timelapse sample scheduler: directed and random events.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tss_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_BAD_LO    = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_BAD_HI    = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam logic [63:0]          USEC_PER_SEC  = 64'd1000000;
    localparam logic [63:0]          STAMP_CLOCK   = 64'd90000;
    localparam logic [TIME_W-1:0]    TIME_MAX      = '1;
    localparam logic [SEQ_W-1:0]     SEQ_MAX       = '1;
    localparam logic [DAY_W-1:0]     DAY_MAX       = '1;
    localparam int PHASE_ITEMS   = 116;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 3000;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] now_time;
        logic [SEQ_W-1:0]  frame_seq;
        logic [DAY_W-1:0]  day_code;
    } t_sched_event;

    typedef struct {
        logic               sample_pending;
        logic               granted;
        logic               rotate_needed;
        logic [STAMP_W-1:0] stamp_90k;
        logic               stamp_valid;
    } t_sched_result;

    // Scheduler state mirror and the queue of results still owed by the block
    class schedule_board;
        logic [IVL_W-1:0]  interval_s;
        logic [RATE_W-1:0] play_rate;
        logic [FPF_W-1:0]  frames_cap;
        logic              request;
        logic [DUE_W-1:0]  next_due;
        logic [SEQ_W-1:0]  taken_seq;
        logic [DAY_W-1:0]  open_day;
        logic [CNT_W-1:0]  frames_written;
        logic [CNT_W-1:0]  frame_index;
        t_sched_result     owed_q[$];
        int                errors;

        function new();
            interval_s     = IVL_RESET;
            play_rate      = RATE_RESET;
            frames_cap     = FPF_RESET;
            request        = 1'b0;
            next_due       = '0;
            taken_seq      = '0;
            open_day       = '0;
            frames_written = '0;
            frame_index    = '0;
            errors         = 0;
        endfunction

        // Register write with the block's clamping rules
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INTERVAL: begin
                    interval_s = data[IVL_W-1:0];
                    if (interval_s < MIN_INTERVAL_SEC) interval_s = MIN_INTERVAL_SEC;
                end
                CFG_RATE: begin
                    play_rate = data[RATE_W-1:0];
                    if (play_rate < MIN_FPS) play_rate = MIN_FPS;
                    if (play_rate > MAX_FPS) play_rate = MAX_FPS;
                end
                CFG_FILE_FRAMES: begin
                    frames_cap = data[FPF_W-1:0];
                    if (frames_cap != 0 && frames_cap < MIN_FILE_FRAMES)
                        frames_cap = MIN_FILE_FRAMES;
                end
                default: ;
            endcase
        endfunction

        function logic [63:0] step_usec();
            return {47'd0, interval_s} * USEC_PER_SEC;
        endfunction

        // Work out the result of one accepted event and update the mirror
        function void note_event(t_sched_event ev);
            t_sched_result r;
            logic [63:0]   step;
            logic [63:0]   sum;
            r = '{default: '0};
            step = step_usec();
            if (open_day == 0)
                r.rotate_needed = 1'b1;
            else if (frames_cap != 0)
                r.rotate_needed = (frames_written >= {16'd0, frames_cap});
            else
                r.rotate_needed = (ev.day_code != open_day);
            case (ev.cmd)
                CMD_TICK: begin
                    sum = {16'd0, ev.now_time} + step;
                    if (next_due == 0) begin
                        request  = 1'b1;
                        next_due = sum[DUE_W-1:0];
                    end else if ({1'b0, ev.now_time} >= next_due) begin
                        request = 1'b1;
                        sum = {15'd0, next_due} + step;
                        next_due = sum[DUE_W-1:0];
                        if (next_due <= {1'b0, ev.now_time}) begin
                            sum = {16'd0, ev.now_time} + step;
                            next_due = sum[DUE_W-1:0];
                        end
                    end
                end
                CMD_FORCE: request = 1'b1;
                CMD_TAKE: begin
                    if (request && ev.frame_seq > taken_seq) begin
                        taken_seq = ev.frame_seq;
                        request   = 1'b0;
                        r.granted = 1'b1;
                    end
                end
                CMD_RING: taken_seq = '0;
                CMD_FILE: begin
                    open_day       = ev.day_code;
                    frames_written = '0;
                    frame_index    = '0;
                end
                CMD_SAMPLE: begin
                    sum = ({32'd0, frame_index} * STAMP_CLOCK) / {57'd0, play_rate};
                    r.stamp_90k   = sum[STAMP_W-1:0];
                    r.stamp_valid = 1'b1;
                    frame_index++;
                    frames_written++;
                end
                default: ;
            endcase
            r.sample_pending = request;
            owed_q.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_sched_result got);
            t_sched_result want;
            if (owed_q.size() == 0) begin
                $error("result with nothing outstanding: stamp_90k %0h", got.stamp_90k);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            compare("sample_pending", 64'(want.sample_pending), 64'(got.sample_pending));
            compare("granted", 64'(want.granted), 64'(got.granted));
            compare("rotate_needed", 64'(want.rotate_needed), 64'(got.rotate_needed));
            compare("stamp_90k", 64'(want.stamp_90k), 64'(got.stamp_90k));
            compare("stamp_valid", 64'(want.stamp_valid), 64'(got.stamp_valid));
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tss_in_if  in_ch ();
    tss_out_if out_ch ();

    timelapse_sample_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    schedule_board     board = new();
    bit                idle_on;
    bit                hold_req;
    int                quiet_cycles;
    logic [TIME_W-1:0] time_cursor;
    logic [SEQ_W-1:0]  seq_cursor;
    logic [DAY_W-1:0]  day_cursor;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, plus one long hold on request
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            out_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            hold_req = 1'b0;
            out_ch.ready <= 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Result check on every output transfer
    always @(posedge i_clk) begin
        t_sched_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.sample_pending = out_ch.sample_pending;
            got.granted        = out_ch.granted;
            got.rotate_needed  = out_ch.rotate_needed;
            got.stamp_90k      = out_ch.stamp_90k;
            got.stamp_valid    = out_ch.stamp_valid;
            board.check_result(got);
        end
    end

    // Watchdog: cycles without any transfer or register write
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one event, with an optional gap first, and note it when transferred
    task automatic send_event(t_sched_event ev);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= ev.cmd;
        in_ch.now_time  <= ev.now_time;
        in_ch.frame_seq <= ev.frame_seq;
        in_ch.day_code  <= ev.day_code;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_event(ev);
    endtask

    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now,
                            logic [SEQ_W-1:0] seq, logic [DAY_W-1:0] day);
        t_sched_event ev;
        ev = '{cmd, now, seq, day};
        send_event(ev);
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // All registers plus a write to the unused index, which must be ignored
    task automatic configure(logic [CFG_DATA_W-1:0] ivl, logic [CFG_DATA_W-1:0] rate,
                             logic [CFG_DATA_W-1:0] frames);
        write_reg(CFG_INTERVAL, ivl);
        write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
        write_reg(CFG_RATE, rate);
        write_reg(CFG_FILE_FRAMES, frames);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    // Tick time: mostly a walk around the schedule, sometimes on its edge or random
    function automatic logic [TIME_W-1:0] pick_tick_time();
        logic [63:0] step;
        logic [63:0] t;
        step = board.step_usec();
        case ($urandom_range(0, 9))
            0: t = {16'd0, rand48()};
            1: t = (board.next_due != 0) ? {15'd0, board.next_due} - 1 : {16'd0, time_cursor};
            2: t = (board.next_due != 0) ? {15'd0, board.next_due} : {16'd0, time_cursor};
            3, 4: t = {16'd0, time_cursor} + step * $urandom_range(2, 5);
            default: t = {16'd0, time_cursor} + (step / 4) * $urandom_range(1, 5);
        endcase
        time_cursor = t[TIME_W-1:0];
        return time_cursor;
    endfunction

    function automatic logic [DAY_W-1:0] pick_day();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) day_cursor++;
        if (pick == 1) return DAY_W'($urandom);
        if (pick == 2) return day_cursor + DAY_W'(1);
        return day_cursor;
    endfunction

    // One random event: mostly meaningful sequences, some noise
    function automatic t_sched_event next_event();
        t_sched_event ev;
        int           pick;
        ev.now_time  = rand48();
        ev.frame_seq = rand48();
        ev.day_code  = pick_day();
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            ev.cmd = CMD_TICK;
            ev.now_time = pick_tick_time();
        end else if (pick < 50) begin
            ev.cmd = CMD_SAMPLE;
        end else if (pick < 70) begin
            ev.cmd = CMD_TAKE;
            if ($urandom_range(0, 9) != 0) begin
                ev.frame_seq = seq_cursor + $urandom_range(0, 3);
                seq_cursor = ev.frame_seq;
            end
        end else if (pick < 78) begin
            ev.cmd = CMD_FORCE;
        end else if (pick < 87) begin
            ev.cmd = CMD_FILE;
            if ($urandom_range(0, 9) == 0) ev.day_code = '0;
        end else if (pick < 93) begin
            ev.cmd = CMD_RING;
            seq_cursor = SEQ_W'($urandom_range(0, 7));
        end else begin
            ev.cmd = ($urandom_range(0, 1) == 0) ? CMD_BAD_LO : CMD_BAD_HI;
        end
        return ev;
    endfunction

    task automatic run_phase(int items);
        repeat (items) send_event(next_event());
    endtask

    // Main sequence
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_TICK;
        in_ch.now_time  = '0;
        in_ch.frame_seq = '0;
        in_ch.day_code  = '0;
        out_ch.ready    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_INTERVAL;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        quiet_cycles    = 0;
        time_cursor     = '0;
        seq_cursor      = '0;
        day_cursor      = DAY_W'($urandom_range(1, 100000));
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, schedule edges, take rules, files and unknown codes
        send_cmd(CMD_SAMPLE, '0, '0, '0);              // no file open yet
        send_cmd(CMD_TAKE, '0, 48'd9, day_cursor);     // nothing requested
        send_cmd(CMD_TICK, '0, '0, day_cursor);        // first tick arms at once
        send_cmd(CMD_TAKE, '0, '0, day_cursor);        // sequence not above last
        send_cmd(CMD_TAKE, '0, 48'd5, day_cursor);
        send_cmd(CMD_TICK, 48'd59_999_999, '0, day_cursor);
        send_cmd(CMD_TICK, 48'd60_000_000, '0, day_cursor);
        send_cmd(CMD_TAKE, '0, 48'd5, day_cursor);     // equal sequence refused
        send_cmd(CMD_RING, TIME_MAX, SEQ_MAX, DAY_MAX);
        send_cmd(CMD_TAKE, '0, 48'd1, day_cursor);
        send_cmd(CMD_TICK, 48'd1_000_000_000, '0, day_cursor); // stall, reschedule
        send_cmd(CMD_FORCE, '0, '0, '0);
        send_cmd(CMD_TAKE, '0, SEQ_MAX, day_cursor);
        send_cmd(CMD_FORCE, TIME_MAX, SEQ_MAX, DAY_MAX);
        send_cmd(CMD_TAKE, '0, SEQ_MAX, day_cursor);
        send_cmd(CMD_FILE, '0, '0, DAY_MAX);
        send_cmd(CMD_SAMPLE, TIME_MAX, SEQ_MAX, DAY_MAX);
        send_cmd(CMD_SAMPLE, '0, '0, DAY_MAX);
        send_cmd(CMD_SAMPLE, '0, '0, '0);              // day change
        send_cmd(CMD_BAD_LO, rand48(), rand48(), DAY_W'($urandom));
        send_cmd(CMD_BAD_HI, rand48(), rand48(), DAY_W'($urandom));
        send_cmd(CMD_FILE, '0, '0, '0);                // day zero closes the file
        send_cmd(CMD_SAMPLE, '0, '0, day_cursor);
        send_cmd(CMD_TICK, TIME_MAX, '0, day_cursor);
        send_cmd(CMD_FILE, '0, '0, day_cursor);
        drain();

        // Random phases over register settings; long receiver hold in the first
        configure(17'd1, 17'd60, 17'd1);
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS);
        drain();
        configure(17'd0, 17'h00080, 17'h10000);
        run_phase(PHASE_ITEMS);
        drain();
        configure(17'd86400, 17'd61, 17'd65535);
        run_phase(PHASE_ITEMS);
        drain();
        configure(17'h1FFFF, 17'h1FFFF, 17'd3);
        run_phase(PHASE_ITEMS);
        drain();

        // Last part without idling
        idle_on = 1'b0;
        configure(CFG_DATA_W'($urandom_range(1, 600)), CFG_DATA_W'($urandom_range(0, 127)),
                  CFG_DATA_W'($urandom_range(0, 6)));
        run_phase(PHASE_ITEMS);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
